// ----- rtl/core/gbn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the go-back-n sender controller and datapath.
// ----------------------------------------------------------------------------
package gbn_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd600;
	localparam logic [3:0]  WINDOW_RESET  = 4'd8;

	// Event kinds on the input channel
	typedef enum logic [1:0] {
		KIND_MSG  = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_MSG_OK      = 3'd0,
		ST_MSG_DROP    = 3'd1,
		ST_ACK_TAKEN   = 3'd2,
		ST_ACK_CORRUPT = 3'd3,
		ST_ACK_IGNORED = 3'd4,
		ST_TIMEOUT     = 3'd5,
		ST_IDLE_TICK   = 3'd6
	} status_t;

	// Input item
	typedef struct packed {
		logic [1:0]         kind;
		logic [31:0]        ack_seq_field;
		logic signed [31:0] ack_number;
		logic [31:0]        ack_check_field;
		logic [15:0]        ack_payload_sum;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic        send_valid;
		logic [30:0] send_seq;
		logic [9:0]  buffer_slot;
		logic        retransmit;
		logic [2:0]  status;
		logic        last;
	} out_item_t;

	// Result to load into the output register
	typedef struct packed {
		logic    valid;
		logic    send;
		logic    retx;
		logic    sel_cur;
		logic    last;
		status_t status;
	} emit_t;

	// Controller to datapath commands
	typedef struct packed {
		logic  latch;
		logic  check;
		logic  msg_send;
		logic  msg_buffer;
		logic  tick_count;
		logic  timer_clear;
		logic  timer_stop;
		logic  cur_load;
		logic  walk_step;
		logic  ack_commit;
		logic  send_new;
		logic  retx_step;
		emit_t emit;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] kind;
		logic       out_free;
		logic       buf_full;
		logic       can_send_now;
		logic       flight_zero;
		logic       ack_ok;
		logic       ack_in_window;
		logic       timer_running;
		logic       timeout_hit;
		logic       walk_done;
		logic       send_ok;
		logic       send_more;
		logic       retx_last;
	} dp_sts_t;

endpackage

// ----- rtl/core/go_back_n_sender_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_top
// Go-Back-N sender control. Events come in one at a time: a message from the
// application, an ACK packet or a timer tick. Each event yields one or more
// results, the final one flagged by last. A message, a rejected ACK or a tick
// goes from accept through checksum check to decision, where its result is
// loaded; a taken ACK then steps the window base and its buffer slot forward
// once per acknowledged packet, commits, and emits a result per newly sent
// packet, or a single bare result when nothing new goes out; a timeout
// emits a result per retransmitted packet. The output register emits one
// result per cycle; a stalled output holds the sequencer and the input stays
// stalled until the item's final result is loaded. Buffer slots are sequence
// modulo BUFFER_DEPTH, kept by counters that step with the sequences, so any
// depth up to 1024 works without a divider. Configuration must be written by
// the user only while no item is being worked on; the block does not enforce it.
// ----------------------------------------------------------------------------
module go_back_n_sender_top import gbn_pkg::*; #(
	parameter int WINDOW_MAX   = 8,
	parameter int BUFFER_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer
	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Pointers, timer, checksum and output register
	gbn_datapath #(
		.WINDOW_MAX   (WINDOW_MAX),
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- rtl/core/gbn_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_datapath
// Sequence pointers, slot counters, retransmit timer, ACK checksum check,
// configuration registers and the output register of the sender.
// ----------------------------------------------------------------------------
module gbn_datapath import gbn_pkg::*; #(
	parameter int WINDOW_MAX   = 8,
	parameter int BUFFER_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts
);

	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int SW = $clog2(BUFFER_DEPTH);
	localparam logic [CW:0]    WMAX_W    = (CW + 1)'(WINDOW_MAX);
	localparam logic [SW-1:0]  SLOT_LAST = SW'(BUFFER_DEPTH - 1);
	localparam logic [30:0]    DEPTH_W   = 31'(BUFFER_DEPTH);

	// End-around-carry add of one halfword
	function automatic logic [15:0] oc_add(input logic [15:0] sum, input logic [15:0] word);
		logic [16:0] t;
		t = {1'b0, sum} + {1'b0, word};
		return t[16] ? (t[15:0] + 16'd1) : t[15:0];
	endfunction

	// Slot of the following sequence; a sequence wrap restarts the slot at zero
	function automatic logic [SW-1:0] slot_inc(input logic [30:0] seq_new,
			input logic [SW-1:0] slot);
		logic [SW-1:0] r;
		if (seq_new == 31'd0 || slot == SLOT_LAST) begin
			r = '0;
		end else begin
			r = slot + SW'(1);
		end
		return r;
	endfunction

	in_item_t       in_q;
	logic           ack_ok_q;
	logic [15:0]    timeout_q;
	logic [3:0]     window_q;
	logic [30:0]    base_q;
	logic [SW-1:0]  base_slot_q;
	logic [30:0]    next_q;
	logic [SW-1:0]  next_slot_q;
	logic [30:0]    end_q;
	logic           run_q;
	logic [15:0]    count_q;
	logic [30:0]    cur_q;
	logic [SW-1:0]  cur_slot_q;
	logic [CW-1:0]  cnt_q;
	logic           out_valid_q;
	out_item_t      out_q;

	logic [CW-1:0]  win_eff;
	logic [30:0]    win_w;
	logic [30:0]    flight;
	logic [30:0]    held;
	logic [30:0]    next_inc;
	logic [30:0]    cur_inc;
	logic [30:0]    ack_target;
	logic [CW-1:0]  flight_lim;
	logic [CW:0]    cnt_inc;
	logic [15:0]    count_new;
	logic [15:0]    csum;
	logic           out_free;
	out_item_t      out_d;

	// Effective window: zero acts as one, clamp to the build limit
	always_comb begin
		if (window_q == 4'd0) begin
			win_eff = CW'(1);
		end else if ({28'd0, window_q} > 32'(WINDOW_MAX)) begin
			win_eff = CW'(WINDOW_MAX);
		end else begin
			win_eff = CW'(window_q);
		end
	end

	assign win_w      = 31'(win_eff);
	assign flight     = next_q - base_q;
	assign held       = end_q - base_q;
	assign next_inc   = next_q + 31'd1;
	assign cur_inc    = cur_q + 31'd1;
	assign ack_target = in_q.ack_number[30:0] + 31'd1;
	assign flight_lim = (flight < win_w) ? flight[CW-1:0] : win_eff;
	assign cnt_inc    = {1'b0, cnt_q} + (CW + 1)'(1);
	assign count_new  = (count_q != 16'hFFFF) ? (count_q + 16'd1) : count_q;
	assign out_free   = !out_valid_q || !out_stall;

	// Ones-complement sum over both halves of the sequence and ACK number fields and the payload sum
	always_comb begin
		csum = 16'd0;
		csum = oc_add(csum, in_q.ack_seq_field[15:0]);
		csum = oc_add(csum, in_q.ack_seq_field[31:16]);
		csum = oc_add(csum, in_q.ack_number[15:0]);
		csum = oc_add(csum, in_q.ack_number[31:16]);
		csum = oc_add(csum, in_q.ack_payload_sum);
	end

	// Status toward the controller
	always_comb begin
		sts.kind          = in_q.kind;
		sts.out_free      = out_free;
		sts.buf_full      = held >= DEPTH_W;
		sts.can_send_now  = (next_q == end_q) && (flight < win_w);
		sts.flight_zero   = flight == 31'd0;
		sts.ack_ok        = ack_ok_q;
		sts.ack_in_window = !in_q.ack_number[31] &&
			((in_q.ack_number[30:0] - base_q) < flight);
		sts.timer_running = run_q;
		sts.timeout_hit   = count_new >= timeout_q;
		sts.walk_done     = cur_q == ack_target;
		sts.send_ok       = (next_q != end_q) && (flight < win_w) && ({1'b0, cnt_q} < WMAX_W);
		sts.send_more     = (next_inc != end_q) && ((next_inc - base_q) < win_w) &&
			(cnt_inc < WMAX_W);
		sts.retx_last     = cnt_inc == {1'b0, flight_lim};
	end

	// Capture the item and its checksum verdict
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			in_q <= in_data;
		end
		if (cmd.check) begin
			ack_ok_q <= in_q.ack_check_field == {16'd0, ~csum};
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			window_q  <= WINDOW_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_wdata;
				CFG_WINDOW:  window_q  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// Window pointers and their slot counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			base_slot_q <= '0;
			next_q      <= '0;
			next_slot_q <= '0;
			end_q       <= '0;
		end else begin
			if (cmd.msg_send || cmd.send_new) begin
				next_q      <= next_inc;
				next_slot_q <= slot_inc(next_inc, next_slot_q);
			end
			if (cmd.msg_send || cmd.msg_buffer) begin
				end_q <= end_q + 31'd1;
			end
			if (cmd.ack_commit) begin
				base_q      <= cur_q;
				base_slot_q <= cur_slot_q;
			end
		end
	end

	// Retransmit timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			count_q <= '0;
		end else begin
			if (cmd.msg_send && next_q == base_q) begin
				run_q   <= 1'b1;
				count_q <= '0;
			end
			if (cmd.tick_count) begin
				count_q <= count_new;
			end
			if (cmd.timer_clear) begin
				count_q <= '0;
			end
			if (cmd.timer_stop) begin
				run_q <= 1'b0;
			end
			if (cmd.ack_commit) begin
				run_q   <= cur_q != next_q;
				count_q <= '0;
			end
			if (cmd.send_new && !run_q) begin
				run_q   <= 1'b1;
				count_q <= '0;
			end
		end
	end

	// Walk cursor and per-item result count
	always_ff @(posedge clk) begin
		if (cmd.cur_load) begin
			cur_q      <= base_q;
			cur_slot_q <= base_slot_q;
		end else if (cmd.walk_step || cmd.retx_step) begin
			cur_q      <= cur_inc;
			cur_slot_q <= slot_inc(cur_inc, cur_slot_q);
		end
		if (cmd.cur_load || cmd.ack_commit) begin
			cnt_q <= '0;
		end else if (cmd.send_new || cmd.retx_step) begin
			cnt_q <= cnt_inc[CW-1:0];
		end
	end

	// Build the result from the selected sequence
	always_comb begin
		logic [30:0]   seq_sel;
		logic [SW-1:0] slot_sel;
		logic [31:0]   slot_ext;
		seq_sel  = cmd.emit.sel_cur ? cur_q : next_q;
		slot_sel = cmd.emit.sel_cur ? cur_slot_q : next_slot_q;
		slot_ext = 32'(slot_sel);
		out_d.send_valid  = cmd.emit.send;
		out_d.send_seq    = cmd.emit.send ? seq_sel : 31'd0;
		out_d.buffer_slot = cmd.emit.send ? slot_ext[9:0] : 10'd0;
		out_d.retransmit  = cmd.emit.send && cmd.emit.retx;
		out_d.status      = cmd.emit.status;
		out_d.last        = cmd.emit.last;
	end

	// Output register: load on emit, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit.valid) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held <= DEPTH_W)
		else $error("buffered count beyond buffer depth");

	a_next_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		flight <= held)
		else $error("next sequence outside buffered range");

	a_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flight <= 31'(WINDOW_MAX))
		else $error("more packets in flight than the window limit");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit.valid |-> out_free)
		else $error("result loaded over an untaken result");

	a_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> count_q == 16'd0)
		else $error("stopped timer holds a count");
`endif

endmodule

// ----- rtl/core/gbn_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer of the sender: takes one event, decides it, then walks the window
// base, sends new packets or retransmits; one result per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module gbn_ctrl import gbn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_EVAL  = 6'b000100,
		S_WALK  = 6'b001000,
		S_SEND  = 6'b010000,
		S_RETX  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = state_q != S_IDLE;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_EVAL;
			end
			S_EVAL: begin
				if (sts.out_free) begin
					state_d         = S_IDLE;
					cmd.emit.valid  = 1'b1;
					cmd.emit.last   = 1'b1;
					case (sts.kind)
						KIND_MSG: begin
							if (sts.buf_full) begin
								cmd.emit.status = ST_MSG_DROP;
							end else if (sts.can_send_now) begin
								cmd.msg_send    = 1'b1;
								cmd.emit.send   = 1'b1;
								cmd.emit.status = ST_MSG_OK;
							end else begin
								cmd.msg_buffer  = 1'b1;
								cmd.emit.status = ST_MSG_OK;
							end
						end
						KIND_ACK: begin
							if (!sts.ack_ok) begin
								cmd.emit.status = ST_ACK_CORRUPT;
							end else if (!sts.ack_in_window) begin
								cmd.emit.status = ST_ACK_IGNORED;
							end else begin
								cmd.emit.valid = 1'b0;
								cmd.emit.last  = 1'b0;
								cmd.cur_load   = 1'b1;
								state_d        = S_WALK;
							end
						end
						KIND_TICK: begin
							if (!sts.timer_running) begin
								cmd.emit.status = ST_IDLE_TICK;
							end else if (sts.timeout_hit) begin
								cmd.timer_clear = 1'b1;
								cmd.emit.status = ST_TIMEOUT;
								if (sts.flight_zero) begin
									cmd.timer_stop = 1'b1;
								end else begin
									cmd.emit.valid = 1'b0;
									cmd.emit.last  = 1'b0;
									cmd.cur_load   = 1'b1;
									state_d        = S_RETX;
								end
							end else begin
								cmd.tick_count  = 1'b1;
								cmd.emit.status = ST_IDLE_TICK;
							end
						end
						default: begin
							cmd.emit.status = ST_IDLE_TICK;
						end
					endcase
				end
			end
			// Advance the cursor to the new base, one sequence a cycle
			S_WALK: begin
				if (sts.walk_done) begin
					cmd.ack_commit = 1'b1;
					state_d        = S_SEND;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_SEND: begin
				if (sts.out_free) begin
					cmd.emit.valid  = 1'b1;
					cmd.emit.status = ST_ACK_TAKEN;
					if (sts.send_ok) begin
						cmd.send_new  = 1'b1;
						cmd.emit.send = 1'b1;
						cmd.emit.last = !sts.send_more;
						if (!sts.send_more) begin
							state_d = S_IDLE;
						end
					end else begin
						cmd.emit.last = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			S_RETX: begin
				if (sts.out_free) begin
					cmd.retx_step      = 1'b1;
					cmd.emit.valid     = 1'b1;
					cmd.emit.send      = 1'b1;
					cmd.emit.retx      = 1'b1;
					cmd.emit.sel_cur   = 1'b1;
					cmd.emit.status    = ST_TIMEOUT;
					cmd.emit.last      = sts.retx_last;
					if (sts.retx_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> state_q == S_CHECK)
		else $error("accepted item did not go to checksum check");

	a_emit_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.msg_send, cmd.msg_buffer, cmd.send_new, cmd.retx_step, cmd.walk_step}))
		else $error("conflicting pointer commands");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit.valid && cmd.emit.last) |=> state_q == S_IDLE)
		else $error("final result did not end the item");
`endif

endmodule
